@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker in brms_chk.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/brms_pkg.sv @@
// ----------------------------------------------------------------------------
// brms_pkg
// Shared constants and types for the block RMS engine.
// ----------------------------------------------------------------------------
package brms_pkg;

    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed result field widths
    localparam int RMS_W  = 16;
    localparam int USED_W = 17;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_LOAD,
        S_DIV,
        S_ROOT
    } t_state;

    // accumulator control
    typedef struct packed {
        logic take;   // request accepted this cycle
        logic clear;  // block finished, start afresh
    } t_acc_ctl;

endpackage

@@ sv/brms_csub.sv @@
// ----------------------------------------------------------------------------
// brms_csub
// Shared compare-and-subtract unit, used by both divider and root steps.
// ----------------------------------------------------------------------------
module brms_csub #(
    parameter int W = 24
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);

    logic [W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];

endmodule

@@ sv/brms_accum.sv @@
// ----------------------------------------------------------------------------
// brms_accum
// Squares each sample and keeps the running sum of squares and the tally.
// ----------------------------------------------------------------------------
module brms_accum #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_SAMPLES = 65536,
    parameter int TALLY_W     = 17,
    parameter int SUM_W       = 47
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  brms_pkg::t_acc_ctl     i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SUM_W-1:0]       o_sum,
    output logic [TALLY_W-1:0]     o_tally,
    output logic                   o_over
);

    import brms_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_BITS - 1;

    logic [SAMPLE_BITS-1:0]   w_mag;
    logic [2*SAMPLE_BITS-1:0] w_prod;
    logic [SUM_W:0]           w_add;
    logic                     w_room;

    logic [SQ_W-1:0]    r_sq;
    logic               r_sq_vld;
    logic [SUM_W-1:0]   r_sum;
    logic [TALLY_W-1:0] r_tally;
    logic               r_over;

    // magnitude; the most negative code maps to 2^(SAMPLE_BITS-1)
    assign w_mag  = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
    assign w_prod = w_mag * w_mag;
    assign w_room = r_tally < TALLY_W'(MAX_SAMPLES);
    assign w_add  = {1'b0, r_sum} + (SUM_W+1)'(r_sq);

    always_ff @(posedge i_clk) begin
        r_sq <= w_prod[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_sq_vld <= 1'b0;
            r_sum    <= '0;
            r_tally  <= '0;
            r_over   <= 1'b0;
        end else begin
            r_sq_vld <= i_ctl.take && w_room;
            if (r_sq_vld) begin
                // saturate on carry (only reachable at the widest settings)
                r_sum <= w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
            end
            if (i_ctl.take) begin
                if (w_room) begin
                    r_tally <= r_tally + 1'b1;
                end else begin
                    r_over <= 1'b1;
                end
            end
        end
    end

    assign o_sum   = r_sum;
    assign o_tally = r_tally;
    assign o_over  = r_over;

endmodule

@@ sv/brms_iter.sv @@
// ----------------------------------------------------------------------------
// brms_iter
// Sequencer: restoring divide then digit-by-digit root on one shared unit.
// ----------------------------------------------------------------------------
module brms_iter #(
    parameter int SUM_W   = 47,
    parameter int TALLY_W = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic                       i_last,
    input  logic [SUM_W-1:0]           i_sum,
    input  logic [TALLY_W-1:0]         i_tally,
    input  logic                       i_over,
    output logic                       o_busy,
    output logic                       o_clear,
    output logic                       o_done,
    output logic [brms_pkg::RMS_W-1:0]  o_rms_value,
    output logic [brms_pkg::USED_W-1:0] o_samples_used,
    output logic                       o_too_many
);

    import brms_pkg::*;

    localparam int R     = (SUM_W + 1) / 2;
    localparam int W2    = 2 * R;
    localparam int CW    = (TALLY_W + 1 > R + 2) ? TALLY_W + 1 : R + 2;
    localparam int CNT_W = $clog2(W2);

    t_state             r_state, n_state;
    logic               r_done,  n_done;
    logic [CW-1:0]      r_rem,   n_rem;
    logic [W2-1:0]      r_work,  n_work;
    logic [R-1:0]       r_root,  n_root;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [TALLY_W-1:0] r_tally, n_tally;
    logic               r_over,  n_over;

    logic [CW-1:0] w_sh_div, w_sh_root, w_trial;
    logic [CW-1:0] w_a, w_b, w_diff;
    logic          w_ge;
    logic          w_clear;

    // next partial remainders
    assign w_sh_div  = {r_rem[CW-2:0], r_work[W2-1]};
    assign w_sh_root = {r_rem[CW-3:0], r_work[W2-1:W2-2]};
    assign w_trial   = CW'({r_root, 2'b01});

    assign w_a = (r_state == S_ROOT) ? w_sh_root : w_sh_div;
    assign w_b = (r_state == S_ROOT) ? w_trial   : CW'(r_tally);

    brms_csub #(.W(CW)) u_csub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_work  <= n_work;
        r_root  <= n_root;
        r_cnt   <= n_cnt;
        r_tally <= n_tally;
        r_over  <= n_over;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_work  = r_work;
        n_root  = r_root;
        n_cnt   = r_cnt;
        n_tally = r_tally;
        n_over  = r_over;
        w_clear = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_take && i_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last square lands in the sum
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_work  = W2'(i_sum);
                n_rem   = '0;
                n_tally = i_tally;
                n_over  = i_over;
                n_cnt   = CNT_W'(W2 - 1);
                w_clear = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = w_ge ? w_diff : w_sh_div;
                n_work = {r_work[W2-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(R - 1);
                    n_state = S_ROOT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ROOT: begin
                n_rem  = w_ge ? w_diff : w_sh_root;
                n_work = {r_work[W2-3:0], 2'b00};
                n_root = {r_root[R-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_clear        = w_clear;
    assign o_done         = r_done;
    assign o_rms_value    = RMS_W'(r_root);
    assign o_samples_used = USED_W'(r_tally);
    assign o_too_many     = r_over;

endmodule

@@ sv/block_rms.sv @@
// ----------------------------------------------------------------------------
// block_rms
// Integer RMS of a block of signed samples, floored throughout.
// ----------------------------------------------------------------------------
// Samples are requested with start while busy is low. A sample without the
// last mark is taken without a stall and busy stays low, so samples can stream
// every cycle. The sample marked last raises busy while the engine steps
// through a drain state that lets the final square land in the sum, a load
// state, the divider at one quotient bit per cycle, then the root at one
// root bit per cycle, all on a single shared compare-subtract unit.
// The result
// (o_rms_value, o_samples_used, o_too_many) is shown for exactly one cycle
// with o_done, the same cycle busy falls; there is no back-pressure, so the
// receiver must take it then. Samples past MAX_SAMPLES are dropped and flag
// o_too_many; the accumulator clears itself once the result is loaded.
// ----------------------------------------------------------------------------
module block_rms #(
    parameter int MAX_SAMPLES = brms_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = brms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    input  logic                        i_last_sample,
    output logic                        o_done,
    output logic [brms_pkg::RMS_W-1:0]  o_rms_value,
    output logic [brms_pkg::USED_W-1:0] o_samples_used,
    output logic                        o_too_many
);

    import brms_pkg::*;

    // tally must hold MAX_SAMPLES itself
    localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
    // squares reach 2^(2*SAMPLE_BITS-2); sum capped at 64 bits (saturating)
    localparam int SUM_RAW = 2 * SAMPLE_BITS - 2 + TALLY_W;
    localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;

    logic               w_take;
    logic               w_busy;
    logic               w_clear;
    t_acc_ctl           w_acc_ctl;
    logic [SUM_W-1:0]   w_sum;
    logic [TALLY_W-1:0] w_tally;
    logic               w_over;

    // request accepted
    assign w_take = start && !w_busy;

    assign w_acc_ctl.take  = w_take;
    assign w_acc_ctl.clear = w_clear;

    brms_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .TALLY_W     (TALLY_W),
        .SUM_W       (SUM_W)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_acc_ctl),
        .i_sample (i_sample),
        .o_sum    (w_sum),
        .o_tally  (w_tally),
        .o_over   (w_over)
    );

    brms_iter #(
        .SUM_W   (SUM_W),
        .TALLY_W (TALLY_W)
    ) u_iter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_last         (i_last_sample),
        .i_sum          (w_sum),
        .i_tally        (w_tally),
        .i_over         (w_over),
        .o_busy         (w_busy),
        .o_clear        (w_clear),
        .o_done         (o_done),
        .o_rms_value    (o_rms_value),
        .o_samples_used (o_samples_used),
        .o_too_many     (o_too_many)
    );

    assign busy = w_busy;

endmodule

@@ sv/brms_chk.sv @@
// ----------------------------------------------------------------------------
// brms_chk
// Port-level timing checks for block_rms, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brms_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_sample,
    input logic o_done
);

    `CHK_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `CHK_NEXT(a_plain_fast, i_clk, i_rst_n,
              start && !busy && !i_last_sample, !busy, "plain request stalled")
    `CHK_NEXT(a_last_busy, i_clk, i_rst_n,
              start && !busy && i_last_sample, busy, "last request did not raise busy")
    `CHK_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe too long")
    `CHK_NOW(a_fall_done, i_clk, i_rst_n,
             $past(i_rst_n) && $fell(busy), o_done, "busy fell without a result")

endmodule

bind block_rms brms_chk u_brms_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_last_sample (i_last_sample),
    .o_done        (o_done)
);

@@ tb/sv/block_rms_tb.sv @@
// ----------------------------------------------------------------------------
// block_rms_tb
// Self-checking bench for the block RMS engine.
// ----------------------------------------------------------------------------
// Sample requests go in on start/busy, with random gaps between them.
// Every accepted request also runs through a local model of the accumulator:
// sum of squares, sample count and the dropped-sample flag. When a request
// carries the last mark, the expected RMS, count and overflow flag are queued.
// Each o_done pulse is checked field by field against the oldest entry in
// that queue.
// The run has two parts:
//   - a short table of hand-picked requests: single-sample extremes, floor
//     cases and bit patterns;
//   - random blocks of mixed length and content.
// ----------------------------------------------------------------------------
module block_rms_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int MAX_SAMPLES    = brms_pkg::MAX_SAMPLES_DEF;
    localparam int RANDOM_TARGET  = 2000;
    // Worst legal quiet stretch: the longest random gap plus the busy spell of a
    // last-marked sample. Take it many times over.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 100;
    localparam int N_DIRECTED     = 22;

    typedef struct packed {
        logic [brms_pkg::RMS_W-1:0]  rms;
        logic [brms_pkg::USED_W-1:0] used;
        logic                        too_many;
    } t_rms_result;

    // One row of the hand-written table. When typed is set, want is the
    // answer read straight off the data. Otherwise the local model supplies it.
    typedef struct packed {
        logic [15:0] sample;
        logic        last;
        logic        typed;
        t_rms_result want;
    } t_dir_row;

    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        // single-sample blocks, straight after reset
        '{16'h0000, 1'b1, 1'b1, '{16'd0,     17'd1, 1'b0}},
        '{16'h7FFF, 1'b1, 1'b1, '{16'd32767, 17'd1, 1'b0}},
        '{16'h8000, 1'b1, 1'b1, '{16'd32768, 17'd1, 1'b0}},
        '{16'hFFFF, 1'b1, 1'b1, '{16'd1,     17'd1, 1'b0}},
        '{16'h0001, 1'b1, 1'b1, '{16'd1,     17'd1, 1'b0}},
        // 9 + 16 = 25, floor(25/2) = 12, root floors to 3
        '{16'd3,    1'b0, 1'b0, '0},
        '{16'd4,    1'b1, 1'b0, '0},
        // sign does not matter, only magnitude
        '{16'd100,  1'b0, 1'b0, '0},
        '{-16'sd100, 1'b0, 1'b0, '0},
        '{16'd100,  1'b0, 1'b0, '0},
        '{-16'sd100, 1'b1, 1'b1, '{16'd100, 17'd4, 1'b0}},
        // mean of squares 2, root floors to 1
        '{16'd1,    1'b0, 1'b0, '0},
        '{16'd1,    1'b0, 1'b0, '0},
        '{16'd2,    1'b1, 1'b0, '0},
        // both extremes in one block
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b1, 1'b0, '0},
        // alternating bit patterns
        '{16'h5555, 1'b0, 1'b0, '0},
        '{16'hAAAA, 1'b1, 1'b0, '0},
        // zeros dilute the mean
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b1, 1'b0, '0},
        '{16'hFFFF, 1'b1, 1'b1, '{16'd1, 17'd1, 1'b0}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_sample;
    logic        i_last_sample;
    logic        o_done;
    logic [brms_pkg::RMS_W-1:0]  o_rms_value;
    logic [brms_pkg::USED_W-1:0] o_samples_used;
    logic        o_too_many;

    // Local model state.
    logic [63:0] acc_sq_sum;
    int unsigned acc_count;
    logic        acc_dropped;

    t_rms_result pending_rms [$];
    int          mismatches      = 0;
    int          results_checked = 0;
    int          requests_sent;
    int          blocks_sent;
    int          quiet_cycles    = 0;

    block_rms dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_last_sample  (i_last_sample),
        .o_done         (o_done),
        .o_rms_value    (o_rms_value),
        .o_samples_used (o_samples_used),
        .o_too_many     (o_too_many)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Floored square root, one bit at a time from the top.
    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = {32'd0, root | (32'd1 << b)};
            if (trial * trial <= x) begin
                root = trial[31:0];
            end
        end
        return root;
    endfunction

    // Feed one accepted sample into the model. Returns 1 and fills res
    // when the sample closes a block.
    function automatic bit rms_accumulate(input logic [15:0] s, input logic last,
                                          output t_rms_result res);
        longint      v;
        logic [63:0] sq;
        logic [63:0] mean;
        logic [31:0] root;
        v  = longint'($signed(s));
        sq = 64'(v * v);
        if (acc_count < MAX_SAMPLES) begin
            // saturate rather than wrap; unreachable at the default sizes
            if (acc_sq_sum > ~64'd0 - sq) begin
                acc_sq_sum = ~64'd0;
            end else begin
                acc_sq_sum = acc_sq_sum + sq;
            end
            acc_count++;
        end else begin
            acc_dropped = 1'b1;
        end
        res = '0;
        if (!last) begin
            return 1'b0;
        end
        mean = (acc_count != 0) ? acc_sq_sum / 64'(acc_count) : 64'd0;
        root = floor_sqrt(mean);
        res.rms      = root[brms_pkg::RMS_W-1:0];
        res.used     = acc_count[brms_pkg::USED_W-1:0];
        res.too_many = acc_dropped;
        acc_sq_sum  = '0;
        acc_count   = 0;
        acc_dropped = 1'b0;
        return 1'b1;
    endfunction

    // Wait a random gap, then raise the request. Hold it until it is taken
    // at an edge where busy is low. start is only lowered when a gap follows,
    // so back-to-back requests keep it high without a glitch.
    task automatic send_sample(input logic [15:0] s, input logic last, input int max_gap,
                               input logic typed, input t_rms_result want);
        int          gap;
        t_rms_result res;
        gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_sample      <= s;
        i_last_sample <= last;
        @(posedge i_clk);
        // busy here still holds its value from before this edge
        while (busy) @(posedge i_clk);
        requests_sent++;
        if (rms_accumulate(s, last, res)) begin
            blocks_sent++;
            pending_rms.push_back(typed ? want : res);
        end
    endtask

    // Weighted towards the extremes and tiny values, otherwise any 16 bits.
    function automatic logic [15:0] pick_sample();
        logic [15:0] small_val;
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: begin
                small_val = 16'($urandom_range(0, 15));
                return $urandom_range(0, 1) ? small_val : -small_val;
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Result checker. The receiver cannot stall, so every o_done pulse
    // is taken at the edge that ends it.
    always @(posedge i_clk) begin
        t_rms_result exp_r;
        if (i_rst_n && o_done) begin
            if (pending_rms.size() == 0) begin
                $display("%0t: unexpected result rms=%0d used=%0d too_many=%0b",
                         $time, o_rms_value, o_samples_used, o_too_many);
                mismatches++;
            end else begin
                exp_r = pending_rms.pop_front();
                results_checked++;
                if (o_rms_value !== exp_r.rms) begin
                    $display("%0t: rms expected %0d got %0d", $time, exp_r.rms, o_rms_value);
                    mismatches++;
                end
                if (o_samples_used !== exp_r.used) begin
                    $display("%0t: samples_used expected %0d got %0d",
                             $time, exp_r.used, o_samples_used);
                    mismatches++;
                end
                if (o_too_many !== exp_r.too_many) begin
                    $display("%0t: too_many expected %0b got %0b",
                             $time, exp_r.too_many, o_too_many);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: counts cycles with neither a request taken nor a result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_rms.size());
            $display("block_rms_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          blk_len;
        int          max_gap;
        int          rand_items;

        start           = 1'b0;
        i_sample        = '0;
        i_last_sample   = 1'b0;
        i_rst_n         = 1'b0;
        acc_sq_sum      = '0;
        acc_count       = 0;
        acc_dropped     = 1'b0;
        requests_sent   = 0;
        blocks_sent     = 0;
        rand_items      = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (DIRECTED[k]) begin
            send_sample(DIRECTED[k].sample, DIRECTED[k].last, 10,
                        DIRECTED[k].typed, DIRECTED[k].want);
        end

        // Random blocks, mostly short, some longer. About a quarter of the
        // blocks run without gaps so samples stream on back-to-back cycles.
        while (rand_items < RANDOM_TARGET) begin
            blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                  : $urandom_range(1, 12);
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
            for (int n = 0; n < blk_len; n++) begin
                send_sample(pick_sample(), n == blk_len - 1, max_gap, 1'b0, '0);
            end
            rand_items += blk_len;
        end
        start <= 1'b0;

        // Drain. The watchdog covers a result that never turns up.
        while (pending_rms.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d sample requests in %0d blocks: hand-picked rows, then random",
                 requests_sent, blocks_sent);
        $display("blocks with and without gaps. Checked %0d results, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && pending_rms.size() == 0) begin
            $display("block_rms_tb OK");
        end else begin
            $display("block_rms_tb NOT OK");
        end
        $finish;
    end

endmodule
